[rtl/aue_pkg.sv]
// Shared types, constants and saturating helpers for the Adam update engine.
// Used by aue_divsqrt and adam_update_engine; no dependencies.
package aue_pkg;

  localparam int PARAM_COUNT_DEF = 4096;
  localparam int VW              = 32;
  localparam int IDX_W           = 12;
  localparam int CFG_W           = 25;
  localparam int OPND_W          = 56;
  localparam int DIVR_W          = 29;
  localparam int ROOT_W          = 28;
  localparam int CNT_W           = 6;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd56;
  localparam logic [CNT_W-1:0] SQRT_STEPS = 6'd28;

  localparam logic [31:0] ONE_Q = 32'h0100_0000;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_GRAD  = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [1:0] CFG_LR  = 2'd0;
  localparam logic [1:0] CFG_B1  = 2'd1;
  localparam logic [1:0] CFG_B2  = 2'd2;
  localparam logic [1:0] CFG_EPS = 2'd3;

  localparam logic [24:0] LR_RESET  = 25'd167772;
  localparam logic [23:0] B1_RESET  = 24'd15099494;
  localparam logic [23:0] B2_RESET  = 24'd16609444;
  localparam logic [15:0] EPS_RESET = 16'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [IDX_W-1:0]  index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [IDX_W-1:0]  entry;
    logic              saturated;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [OPND_W-1:0] operand;
    logic [DIVR_W-1:0] divisor;
  } ds_req_t;

  typedef struct packed {
    logic              done;
    logic [OPND_W-1:0] result;
  } ds_rsp_t;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } clamp_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    logic [31:0] u;
    u = a;
    return a[31] ? 32'(-u) : u;
  endfunction

  function automatic clamp_t clamp_mag(input logic neg, input logic [OPND_W-1:0] m);
    clamp_t r;
    logic [OPND_W-1:0] lim;
    logic [31:0] low;
    lim = neg ? OPND_W'(32'h8000_0000) : OPND_W'(32'h7FFF_FFFF);
    r.sat = m > lim;
    low = r.sat ? lim[31:0] : m[31:0];
    r.val = neg ? 32'(-low) : low;
    return r;
  endfunction

  function automatic clamp_t sat_add(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
    clamp_t r;
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    r.sat = s[32] ^ s[31];
    r.val = r.sat ? (s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s[31:0];
    return r;
  endfunction

  function automatic clamp_t sat_sub(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
    clamp_t r;
    logic [32:0] s;
    s = {a[31], a} - {b[31], b};
    r.sat = s[32] ^ s[31];
    r.val = r.sat ? (s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s[31:0];
    return r;
  endfunction

endpackage

[rtl/adam_update_engine.sv]
// Adam update engine: a gradient runs a 28-step root (if the corrected second
// moment is positive) and a 56-step divide on the shared unit and makes eight
// passes through one 32x32 multiplier; a step runs up to two 56-step divides.
// One request at a time; input stalls until the result is handed to the output register.
// Synchronous reset restores config defaults, powers and corrections to 1.0 and
// the step count to zero; weight and moment tables are not cleared.
module adam_update_engine #(
  parameter int PARAM_COUNT = aue_pkg::PARAM_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  aue_pkg::in_item_t        in_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output aue_pkg::out_item_t       out_rsp,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [aue_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(PARAM_COUNT);

  localparam logic [4:0] S_IDLE = 5'd0,  S_LOADW = 5'd1,  S_FETCH = 5'd2,
                         S_RDX  = 5'd3,  S_G1    = 5'd4,  S_G2    = 5'd5,
                         S_G3   = 5'd6,  S_G4    = 5'd7,  S_G5    = 5'd8,
                         S_G6   = 5'd9,  S_G7    = 5'd10, S_G8    = 5'd11,
                         S_GSQ  = 5'd12, S_GDS   = 5'd13, S_GDIV  = 5'd14,
                         S_GLR  = 5'd15, S_GW    = 5'd16, S_P1    = 5'd17,
                         S_P2   = 5'd18, S_P3    = 5'd19, S_C1    = 5'd20,
                         S_P4   = 5'd21, S_C2    = 5'd22, S_DONE  = 5'd23;

  logic [4:0] state;

  logic [24:0] lr;
  logic [23:0] b1;
  logic [23:0] b2;
  logic [15:0] eps;
  logic [31:0] fp, sp, c1, c2, step_count;

  logic [1:0]                 act;
  logic [aue_pkg::IDX_W-1:0]  idx;
  logic signed [31:0]         g;
  logic                       sat;
  logic signed [31:0]         t1, gsq, m_new, v_new, mc, ratio, w_res;
  logic [aue_pkg::IDX_W-1:0]  entry;
  logic [aue_pkg::ROOT_W-1:0] root;

  logic [63:0] prod;
  logic        prod_neg;
  logic [31:0] mul_a, mul_b;
  logic        mul_neg;
  aue_pkg::clamp_t cl, sa, ss, rc;

  logic                      we;
  logic [AW-1:0]             addr;
  logic signed [31:0]        w_wr, m_wr, v_wr, w_rd, m_rd, v_rd;

  aue_pkg::ds_req_t ds_req;
  aue_pkg::ds_rsp_t ds_rsp;

  logic                       accept;
  logic                       out_free;
  logic [31:0]                pdiff;
  logic [aue_pkg::DIVR_W-1:0] gdiv;
  logic [aue_pkg::OPND_W-1:0] qnum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign addr      = AW'(idx);

  aue_ram #(.WIDTH(32), .DEPTH(PARAM_COUNT)) u_w (
    .clk(clk), .we(we), .addr(addr), .wdata(w_wr), .rdata(w_rd));
  aue_ram #(.WIDTH(32), .DEPTH(PARAM_COUNT)) u_m (
    .clk(clk), .we(we), .addr(addr), .wdata(m_wr), .rdata(m_rd));
  aue_ram #(.WIDTH(32), .DEPTH(PARAM_COUNT)) u_v (
    .clk(clk), .we(we), .addr(addr), .wdata(v_wr), .rdata(v_rd));

  aue_divsqrt u_ds (.clk(clk), .rst(rst), .req(ds_req), .rsp(ds_rsp));

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (state)
      S_G1: begin
        mul_a = aue_pkg::mag32(m_rd); mul_b = 32'(b1); mul_neg = m_rd[31];
      end
      S_G2: begin
        mul_a = aue_pkg::mag32(g); mul_b = aue_pkg::ONE_Q - 32'(b1); mul_neg = g[31];
      end
      S_G3: begin
        mul_a = aue_pkg::mag32(g); mul_b = aue_pkg::mag32(g);
      end
      S_G4: begin
        mul_a = aue_pkg::mag32(v_rd); mul_b = 32'(b2); mul_neg = v_rd[31];
      end
      S_G5: begin
        mul_a = aue_pkg::mag32(gsq); mul_b = aue_pkg::ONE_Q - 32'(b2); mul_neg = gsq[31];
      end
      S_G6: begin
        mul_a = aue_pkg::mag32(m_new); mul_b = c1; mul_neg = m_new[31];
      end
      S_G7: begin
        mul_a = aue_pkg::mag32(v_new); mul_b = c2; mul_neg = v_new[31];
      end
      S_GLR: begin
        mul_a = aue_pkg::mag32(ratio); mul_b = 32'(lr); mul_neg = ratio[31];
      end
      S_P1: begin
        mul_a = fp; mul_b = 32'(b1);
      end
      S_P2: begin
        mul_a = sp; mul_b = 32'(b2);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_neg <= mul_neg;
  end

  always_comb begin
    cl = aue_pkg::clamp_mag(prod_neg, {16'b0, prod[63:24]});
    sa = aue_pkg::sat_add(t1, cl.val);
    ss = aue_pkg::sat_sub(w_rd, cl.val);
    rc = aue_pkg::clamp_mag(mc[31], ds_rsp.result);
    pdiff = (state == S_P3) ? fp : sp;
    pdiff = (pdiff < aue_pkg::ONE_Q) ? aue_pkg::ONE_Q - pdiff : 32'd0;
    gdiv = aue_pkg::DIVR_W'(root) + aue_pkg::DIVR_W'(eps);
    if (gdiv == '0) begin
      gdiv = aue_pkg::DIVR_W'(1);
    end
    qnum = aue_pkg::OPND_W'(1) << 48;
  end

  always_comb begin
    ds_req = '0;
    we     = 1'b0;
    w_wr   = w_rd;
    m_wr   = m_new;
    v_wr   = v_new;
    unique case (state) inside
      S_LOADW: begin
        we = 1'b1; w_wr = g; m_wr = '0; v_wr = '0;
      end
      S_GW: begin
        we = 1'b1; w_wr = ss.val;
      end
      S_G8: begin
        ds_req.start     = (cl.val > 0);
        ds_req.sqrt_mode = 1'b1;
        ds_req.operand   = {cl.val[31:0], 24'b0};
      end
      S_GDS: begin
        ds_req.start   = 1'b1;
        ds_req.operand = {aue_pkg::mag32(mc), 24'b0};
        ds_req.divisor = gdiv;
      end
      S_P3, S_P4: begin
        ds_req.start   = (pdiff != 32'd0);
        ds_req.operand = qnum;
        ds_req.divisor = aue_pkg::DIVR_W'(pdiff);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      lr         <= aue_pkg::LR_RESET;
      b1         <= aue_pkg::B1_RESET;
      b2         <= aue_pkg::B2_RESET;
      eps        <= aue_pkg::EPS_RESET;
      fp         <= aue_pkg::ONE_Q;
      sp         <= aue_pkg::ONE_Q;
      c1         <= aue_pkg::ONE_Q;
      c2         <= aue_pkg::ONE_Q;
      step_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          aue_pkg::CFG_LR:  lr  <= cfg_data;
          aue_pkg::CFG_B1:  b1  <= cfg_data[23:0];
          aue_pkg::CFG_B2:  b2  <= cfg_data[23:0];
          aue_pkg::CFG_EPS: eps <= cfg_data[15:0];
          default:          lr  <= lr;
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act   <= in_req.action;
            idx   <= in_req.index;
            g     <= in_req.value;
            sat   <= 1'b0;
            entry <= (in_req.action == aue_pkg::ACT_STEP) ? '0 : in_req.index;
            w_res <= '0;
            if (in_req.action == aue_pkg::ACT_STEP) begin
              state <= S_P1;
            end else if (!(32'(in_req.index) < PARAM_COUNT)) begin
              state <= S_DONE;
            end else if (in_req.action == aue_pkg::ACT_LOAD) begin
              state <= S_LOADW;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_LOADW: begin
          w_res <= g;
          state <= S_DONE;
        end
        S_FETCH: state <= (act == aue_pkg::ACT_READ) ? S_RDX : S_G1;
        S_RDX: begin
          w_res <= w_rd;
          state <= S_DONE;
        end
        S_G1: state <= S_G2;
        S_G2: begin
          t1 <= cl.val; sat <= sat | cl.sat; state <= S_G3;
        end
        S_G3: begin
          m_new <= sa.val; sat <= sat | cl.sat | sa.sat; state <= S_G4;
        end
        S_G4: begin
          gsq <= cl.val; sat <= sat | cl.sat; state <= S_G5;
        end
        S_G5: begin
          t1 <= cl.val; sat <= sat | cl.sat; state <= S_G6;
        end
        S_G6: begin
          v_new <= sa.val; sat <= sat | cl.sat | sa.sat; state <= S_G7;
        end
        S_G7: begin
          mc <= cl.val; sat <= sat | cl.sat; state <= S_G8;
        end
        S_G8: begin
          sat <= sat | cl.sat;
          root <= '0;
          state <= (cl.val > 0) ? S_GSQ : S_GDS;
        end
        S_GSQ: begin
          if (ds_rsp.done) begin
            root  <= ds_rsp.result[aue_pkg::ROOT_W-1:0];
            state <= S_GDS;
          end
        end
        S_GDS: state <= S_GDIV;
        S_GDIV: begin
          if (ds_rsp.done) begin
            ratio <= rc.val; sat <= sat | rc.sat; state <= S_GLR;
          end
        end
        S_GLR: state <= S_GW;
        S_GW: begin
          w_res <= ss.val; sat <= sat | cl.sat | ss.sat; state <= S_DONE;
        end
        S_P1: begin
          step_count <= step_count + 32'd1;
          state <= S_P2;
        end
        S_P2: begin
          fp <= prod[55:24]; state <= S_P3;
        end
        S_P3: begin
          sp <= prod[55:24];
          if (pdiff == 32'd0) begin
            c1 <= 32'hFFFF_FFFF; sat <= 1'b1; state <= S_P4;
          end else begin
            state <= S_C1;
          end
        end
        S_C1: begin
          if (ds_rsp.done) begin
            if (ds_rsp.result > aue_pkg::OPND_W'(32'hFFFF_FFFF)) begin
              c1 <= 32'hFFFF_FFFF; sat <= 1'b1;
            end else begin
              c1 <= ds_rsp.result[31:0];
            end
            state <= S_P4;
          end
        end
        S_P4: begin
          if (pdiff == 32'd0) begin
            c2 <= 32'hFFFF_FFFF; sat <= 1'b1; state <= S_DONE;
          end else begin
            state <= S_C2;
          end
        end
        S_C2: begin
          if (ds_rsp.done) begin
            if (ds_rsp.result > aue_pkg::OPND_W'(32'hFFFF_FFFF)) begin
              c2 <= 32'hFFFF_FFFF; sat <= 1'b1;
            end else begin
              c2 <= ds_rsp.result[31:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_rsp.weight    <= w_res;
            out_rsp.entry     <= entry;
            out_rsp.saturated <= sat;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/aue_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module aue_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/aue_divsqrt.sv]
// Shared iterative unit: one-bit restoring division or digit-by-digit square root.
// Depends on aue_pkg.
module aue_divsqrt (
  input  logic             clk,
  input  logic             rst,
  input  aue_pkg::ds_req_t req,
  output aue_pkg::ds_rsp_t rsp
);

  logic                        busy;
  logic                        sqrt_mode;
  logic [aue_pkg::CNT_W-1:0]   count;
  logic [aue_pkg::OPND_W-1:0]  opnd;
  logic [aue_pkg::OPND_W-1:0]  res;
  logic [30:0]                 rem;
  logic [aue_pkg::DIVR_W-1:0]  divisor;
  logic                        done;

  logic [30:0] a;
  logic [30:0] b;
  logic [31:0] diff;
  logic        ge;

  always_comb begin
    if (sqrt_mode) begin
      a = {rem[28:0], opnd[aue_pkg::OPND_W-1 -: 2]};
      b = {1'b0, res[aue_pkg::ROOT_W-1:0], 2'b01};
    end else begin
      a = {rem[29:0], opnd[aue_pkg::OPND_W-1]};
      b = {2'b00, divisor};
    end
    diff = {1'b0, a} - {1'b0, b};
    ge   = ~diff[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == aue_pkg::CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == aue_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
    if (req.start) begin
      sqrt_mode <= req.sqrt_mode;
      opnd      <= req.operand;
      divisor   <= req.divisor;
      res       <= '0;
      rem       <= '0;
      count     <= req.sqrt_mode ? aue_pkg::SQRT_STEPS : aue_pkg::DIV_STEPS;
    end else if (busy) begin
      rem   <= ge ? diff[30:0] : a;
      res   <= {res[aue_pkg::OPND_W-2:0], ge};
      opnd  <= sqrt_mode ? {opnd[aue_pkg::OPND_W-3:0], 2'b00}
                         : {opnd[aue_pkg::OPND_W-2:0], 1'b0};
      count <= count - aue_pkg::CNT_W'(1);
    end
  end

  assign rsp.done   = done;
  assign rsp.result = res;

endmodule

[tb/tb_adam_update_engine.sv]
// Self-checking testbench for adam_update_engine: loads, gradients, steps and reads
// are checked against an in-bench Adam predictor across several register settings.
// Depends on rtl/aue_pkg.sv and rtl/adam_update_engine.sv.
`timescale 1ns / 1ps

module tb_adam_update_engine;

  localparam int NUM_ENTRIES = 4096;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  aue_pkg::in_item_t in_req;
  logic out_valid;
  logic out_stall;
  aue_pkg::out_item_t out_rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [aue_pkg::CFG_W-1:0] cfg_data;

  adam_update_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [31:0] weight_tab [NUM_ENTRIES];
  logic signed [31:0] m_tab [NUM_ENTRIES];
  logic signed [31:0] v_tab [NUM_ENTRIES];
  logic [31:0] beta1_pow, beta2_pow, corr1, corr2;
  logic [31:0] step_cnt;
  logic [24:0] alpha;
  logic [23:0] beta1, beta2;
  logic [15:0] eps;

  aue_pkg::in_item_t pending_reqs[$];
  aue_pkg::out_item_t weights_due[$];
  int known_idx[$];
  bit loaded [NUM_ENTRIES];
  int mismatches;
  logic req_fired;
  int burst_left, gap_left, stall_left, stall_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic signed [31:0] clamp_sign(input bit neg, input logic [127:0] mag,
                                                   inout bit sat);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? 32'(-mag[31:0]) : mag[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a, input logic [31:0] b,
                                             inout bit sat);
    longint ma;
    logic [127:0] p;
    ma = longint'(a);
    if (ma < 0) ma = -ma;
    p = 128'(ma) * 128'(b);
    return clamp_sign(a < 0, p >> 24, sat);
  endfunction

  function automatic logic signed [31:0] add_sat(input longint s, inout bit sat);
    if (s > VMAX) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (s < VMIN) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return 32'(s);
  endfunction

  function automatic logic [31:0] int_root(input logic [63:0] x);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (64'(c) * 64'(c) <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] bias_corr(input logic [31:0] p, inout bit sat);
    logic [63:0] d, c;
    d = (p < aue_pkg::ONE_Q) ? 64'(aue_pkg::ONE_Q - p) : 64'd0;
    c = (d == 0) ? 64'h1_0000_0000 : (64'd1 << 48) / d;
    if (c > 64'hFFFF_FFFF) begin
      c = 64'hFFFF_FFFF;
      sat = 1'b1;
    end
    return c[31:0];
  endfunction

  function automatic aue_pkg::out_item_t predict_update(input aue_pkg::in_item_t r);
    aue_pkg::out_item_t o;
    bit sat;
    int i;
    logic signed [31:0] g, m, v, gsq, mc, vc, ratio, delta;
    longint gg;
    logic [31:0] root;
    logic [63:0] divisor;
    logic [127:0] quot;
    sat = 1'b0;
    i = int'(r.index);
    o.weight = '0;
    o.entry = r.index;
    case (r.action)
      aue_pkg::ACT_STEP: begin
        step_cnt = step_cnt + 32'd1;
        beta1_pow = 32'((64'(beta1_pow) * 64'(beta1)) >> 24);
        beta2_pow = 32'((64'(beta2_pow) * 64'(beta2)) >> 24);
        corr1 = bias_corr(beta1_pow, sat);
        corr2 = bias_corr(beta2_pow, sat);
        o.entry = '0;
      end
      aue_pkg::ACT_LOAD: begin
        weight_tab[i] = r.value;
        m_tab[i] = '0;
        v_tab[i] = '0;
      end
      aue_pkg::ACT_GRAD: begin
        g = r.value;
        m = add_sat(longint'(qmul(m_tab[i], 32'(beta1), sat))
                    + longint'(qmul(g, aue_pkg::ONE_Q - 32'(beta1), sat)), sat);
        gg = longint'(g) * longint'(g);
        gsq = add_sat(gg >>> 24, sat);
        v = add_sat(longint'(qmul(v_tab[i], 32'(beta2), sat))
                    + longint'(qmul(gsq, aue_pkg::ONE_Q - 32'(beta2), sat)), sat);
        m_tab[i] = m;
        v_tab[i] = v;
        mc = qmul(m, corr1, sat);
        vc = qmul(v, corr2, sat);
        root = (vc > 0) ? int_root(64'(vc) << 24) : 32'd0;
        divisor = 64'(root) + 64'(eps);
        if (divisor == 0) divisor = 64'd1;
        gg = longint'(mc);
        if (gg < 0) gg = -gg;
        quot = (128'(gg) << 24) / 128'(divisor);
        ratio = clamp_sign(mc < 0, quot, sat);
        delta = qmul(ratio, 32'(alpha), sat);
        weight_tab[i] = add_sat(longint'(weight_tab[i]) - longint'(delta), sat);
      end
      default: ;
    endcase
    if (r.action != aue_pkg::ACT_STEP) o.weight = weight_tab[i];
    o.saturated = sat;
    return o;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    aue_pkg::out_item_t exp_rsp;
    req_fired <= in_valid && !in_stall && !rst;
    if (rst) begin
      beta1_pow = aue_pkg::ONE_Q;
      beta2_pow = aue_pkg::ONE_Q;
      corr1 = aue_pkg::ONE_Q;
      corr2 = aue_pkg::ONE_Q;
      step_cnt = '0;
      alpha = aue_pkg::LR_RESET;
      beta1 = aue_pkg::B1_RESET;
      beta2 = aue_pkg::B2_RESET;
      eps = aue_pkg::EPS_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (weights_due.size() == 0) begin
          flag_mismatch("unexpected result, entry", out_rsp.entry, -1);
        end else begin
          exp_rsp = weights_due.pop_front();
          if (out_rsp.weight !== exp_rsp.weight)
            flag_mismatch("weight", out_rsp.weight, exp_rsp.weight);
          if (out_rsp.entry !== exp_rsp.entry)
            flag_mismatch("entry", out_rsp.entry, exp_rsp.entry);
          if (out_rsp.saturated !== exp_rsp.saturated)
            flag_mismatch("saturated", out_rsp.saturated, exp_rsp.saturated);
        end
      end
      if (in_valid && !in_stall) weights_due.push_back(predict_update(in_req));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aue_pkg::CFG_LR: alpha = cfg_data[24:0];
          aue_pkg::CFG_B1: beta1 = cfg_data[23:0];
          aue_pkg::CFG_B2: beta2 = cfg_data[23:0];
          aue_pkg::CFG_EPS: eps = cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // request driver: bursts with random gaps
  always @(negedge clk) begin
    logic nxt_valid;
    aue_pkg::in_item_t nxt_req;
    nxt_valid = in_valid;
    nxt_req = in_req;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || req_fired) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        nxt_req = pending_reqs.pop_front();
        nxt_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        end
      end
    end
    in_valid <= nxt_valid;
    in_req <= nxt_req;
  end

  // result stall pattern
  always @(negedge clk) begin
    logic nxt_stall;
    if (stall_left <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 400);
    end
    stall_left--;
    case (stall_mode)
      1: nxt_stall = $urandom_range(0, 1);
      2: nxt_stall = $urandom_range(0, 7) != 0;
      default: nxt_stall = 1'b0;
    endcase
    out_stall <= nxt_stall;
  end

  task automatic queue_req(input logic [1:0] act, input int idx, input logic [31:0] val);
    aue_pkg::in_item_t r;
    r.action = act;
    r.index = aue_pkg::IDX_W'(idx);
    r.value = val;
    if (act == aue_pkg::ACT_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      known_idx.push_back(idx);
    end
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [aue_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_reqs.size() != 0 || in_valid || weights_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  task automatic queue_random(input int count);
    int pick, idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15 || known_idx.size() == 0) begin
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_ENTRIES - 1)
                                          : $urandom_range(0, 15);
        queue_req(aue_pkg::ACT_LOAD, idx, rand_value());
      end else begin
        idx = known_idx[$urandom_range(0, known_idx.size() - 1)];
        if (pick < 65) queue_req(aue_pkg::ACT_GRAD, idx, rand_value());
        else if (pick < 80)
          queue_req(aue_pkg::ACT_STEP, $urandom_range(0, NUM_ENTRIES - 1), $urandom);
        else queue_req(aue_pkg::ACT_READ, idx, $urandom);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = aue_pkg::CFG_LR;
    cfg_data = '0;
    mismatches = 0;
    burst_left = 1;
    gap_left = 0;
    stall_left = 0;
    stall_mode = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_req(aue_pkg::ACT_LOAD, 0, 32'h7FFF_FFFF);
    queue_req(aue_pkg::ACT_LOAD, NUM_ENTRIES - 1, 32'h8000_0000);
    queue_req(aue_pkg::ACT_LOAD, 1, 32'h0);
    queue_req(aue_pkg::ACT_READ, 0, 32'hFFFF_FFFF);
    queue_req(aue_pkg::ACT_READ, NUM_ENTRIES - 1, 32'h0);
    queue_req(aue_pkg::ACT_GRAD, 0, 32'h7FFF_FFFF);
    queue_req(aue_pkg::ACT_GRAD, NUM_ENTRIES - 1, 32'h8000_0000);
    queue_req(aue_pkg::ACT_GRAD, 1, 32'h0);
    queue_req(aue_pkg::ACT_STEP, NUM_ENTRIES - 1, 32'hFFFF_FFFF);
    queue_req(aue_pkg::ACT_GRAD, 1, 32'h0100_0000);
    queue_req(aue_pkg::ACT_GRAD, 1, 32'hFF00_0000);
    queue_req(aue_pkg::ACT_STEP, 0, 32'h0);
    queue_req(aue_pkg::ACT_GRAD, 0, 32'h8000_0000);
    queue_req(aue_pkg::ACT_READ, 1, 32'h5555_5555);
    queue_req(aue_pkg::ACT_LOAD, 2, 32'hAAAA_AAAA);
    queue_req(aue_pkg::ACT_GRAD, 2, 32'h0000_0001);
    drain();

    // alpha of 1.0, decays at their top so corrections clamp, widest epsilon
    write_reg(aue_pkg::CFG_LR, 25'd16777216);
    write_reg(aue_pkg::CFG_B1, 25'hFF_FFFF);
    write_reg(aue_pkg::CFG_B2, 25'hFF_FFFF);
    write_reg(aue_pkg::CFG_EPS, 25'hFFFF);
    queue_req(aue_pkg::ACT_STEP, 0, 32'h0);
    queue_req(aue_pkg::ACT_GRAD, 0, 32'h7FFF_FFFF);
    queue_random(330);
    drain();

    write_reg(aue_pkg::CFG_LR, 25'd0);
    write_reg(aue_pkg::CFG_B1, 25'd0);
    write_reg(aue_pkg::CFG_B2, 25'd0);
    write_reg(aue_pkg::CFG_EPS, 25'd1);
    queue_random(330);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      write_reg(aue_pkg::CFG_LR, aue_pkg::CFG_W'($urandom_range(0, 16777216)));
      write_reg(aue_pkg::CFG_B1, aue_pkg::CFG_W'($urandom_range(0, 16777215)));
      write_reg(aue_pkg::CFG_B2, aue_pkg::CFG_W'($urandom_range(0, 16777215)));
      write_reg(aue_pkg::CFG_EPS, aue_pkg::CFG_W'($urandom_range(1, 65535)));
      queue_random(330);
      drain();
    end

    write_reg(aue_pkg::CFG_LR, aue_pkg::LR_RESET);
    write_reg(aue_pkg::CFG_B1, aue_pkg::CFG_W'(aue_pkg::B1_RESET));
    write_reg(aue_pkg::CFG_B2, aue_pkg::CFG_W'(aue_pkg::B2_RESET));
    write_reg(aue_pkg::CFG_EPS, aue_pkg::CFG_W'(aue_pkg::EPS_RESET));
    queue_random(330);
    drain();
    repeat (200) @(posedge clk);

    if (mismatches == 0 && weights_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
